// ----- hdl/gfr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types, codes and helpers of the streaming matrix-vector FMA block.
// ----------------------------------------------------------------------------
package gfr_pkg;

   localparam int N_MAX_DEFAULT = 256;
   localparam int K_MAX_DEFAULT = 1024;

   localparam int COMMAND_W   = 2;
   localparam int VALUE_W     = 32;
   localparam int COLUMN_W    = 8;
   localparam int COUNT_K_W   = 11;
   localparam int COUNT_N_W   = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 16;
   localparam int PIPE_STAGES = 8;

   localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
   localparam logic [31:0] INF32  = 32'h7F80_0000;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_ROW  = 2'd1,
      CMD_ELEM = 2'd2
   } gfr_cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COUNT_K   = 2'd0,
      CSR_COUNT_N   = 2'd1,
      CSR_ZERO_MODE = 2'd2
   } gfr_csr_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_FMA  = 1'b1
   } gfr_op_kind_type;

   typedef struct packed {
      gfr_op_kind_type kind;
      logic            use_zero;
      logic            emit;
      logic            last;
      logic [31:0]     a;
      logic [31:0]     b;
   } gfr_op_type;

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [31:0]         result_value;
      logic                last;
   } gfr_rsp_type;

   function automatic logic [5:0] top_bit64(input logic [63:0] v);
      logic [5:0] t;
      t = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            t = 6'(i);
         end
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/gfr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/gfr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module gfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full,
   output logic      [CW-1:0]    count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/gfr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_front
// Holds the configuration, the row multiplier and the row, column and
// preload positions, and turns each accepted element or load word into a queued operation.
// ----------------------------------------------------------------------------
module gfr_front import gfr_pkg::*; #(
   parameter int N_MAX = N_MAX_DEFAULT,
   parameter int K_MAX = K_MAX_DEFAULT,
   localparam int CW = (N_MAX > 1) ? $clog2(N_MAX) : 1,
   localparam int KW = (K_MAX > 1) ? $clog2(K_MAX) : 1,
   localparam int QW = CW + $bits(gfr_op_type)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COMMAND_W-1:0]   req_command,
   input  wire logic [VALUE_W-1:0]     req_value,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                   q_full,
   output logic                        q_push,
   output logic      [QW-1:0]          q_push_data
);

   logic [COUNT_K_W-1:0] count_k_ff, count_k_in;
   logic [COUNT_N_W-1:0] count_n_ff, count_n_in;
   logic                 zero_mode_ff, zero_mode_in;
   logic [31:0]          row_mult_ff, row_mult_in;
   logic [KW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [CW-1:0]        pre_ff, pre_in;

   logic [16:0]   k_eff;
   logic [12:0]   n_eff;
   logic [KW-1:0] k_last;
   logic [CW-1:0] n_last;
   logic          accept;
   logic [CW-1:0] push_col;
   gfr_op_type    push_op;

   always_comb begin
      if (count_k_ff == '0) begin
         k_eff = 17'd1;
      end else if ({6'b0, count_k_ff} > 17'(K_MAX)) begin
         k_eff = 17'(K_MAX);
      end else begin
         k_eff = {6'b0, count_k_ff};
      end
      if (count_n_ff == '0) begin
         n_eff = 13'd1;
      end else if ({4'b0, count_n_ff} > 13'(N_MAX)) begin
         n_eff = 13'(N_MAX);
      end else begin
         n_eff = {4'b0, count_n_ff};
      end
   end

   assign k_last    = KW'(k_eff - 17'd1);
   assign n_last    = CW'(n_eff - 13'd1);
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      count_k_in   = count_k_ff;
      count_n_in   = count_n_ff;
      zero_mode_in = zero_mode_ff;
      row_mult_in  = row_mult_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pre_in       = pre_ff;
      q_push       = 1'b0;
      push_col     = col_ff;
      push_op      = '0;
      if (csr_write_enable) begin
         unique case (gfr_csr_type'(csr_index))
            CSR_COUNT_K: begin
               count_k_in = csr_write_data[COUNT_K_W-1:0];
               row_in = '0; col_in = '0; pre_in = '0;
            end
            CSR_COUNT_N: begin
               count_n_in = csr_write_data[COUNT_N_W-1:0];
               row_in = '0; col_in = '0; pre_in = '0;
            end
            CSR_ZERO_MODE: begin
               zero_mode_in = csr_write_data[0];
               row_in = '0; col_in = '0; pre_in = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         unique case (gfr_cmd_type'(req_command))
            CMD_LOAD: begin
               q_push       = 1'b1;
               push_col     = pre_ff;
               push_op.kind = OP_LOAD;
               push_op.b    = req_value;
               pre_in       = (pre_ff == n_last) ? '0 : pre_ff + CW'(1);
            end
            CMD_ROW: begin
               row_mult_in = req_value;
            end
            CMD_ELEM: begin
               q_push           = 1'b1;
               push_col         = col_ff;
               push_op.kind     = OP_FMA;
               push_op.use_zero = (row_ff == '0) && zero_mode_ff;
               push_op.emit     = (row_ff == k_last);
               push_op.last     = (col_ff == n_last);
               push_op.a        = row_mult_ff;
               push_op.b        = req_value;
               if (col_ff == n_last) begin
                  col_in = '0;
                  row_in = (row_ff == k_last) ? '0 : row_ff + KW'(1);
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign q_push_data = {push_col, push_op};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_k_ff   <= COUNT_K_W'(1);
         count_n_ff   <= COUNT_N_W'(1);
         zero_mode_ff <= 1'b1;
         row_mult_ff  <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         pre_ff       <= '0;
      end else begin
         count_k_ff   <= count_k_in;
         count_n_ff   <= count_n_in;
         zero_mode_ff <= zero_mode_in;
         row_mult_ff  <= row_mult_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pre_ff       <= pre_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/gfr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_back
// Issues queued operations against the accumulator RAM and runs the
// eight-stage fused multiply-add pipeline with column interlock.
// ----------------------------------------------------------------------------
module gfr_back import gfr_pkg::*; #(
   parameter int N_MAX = N_MAX_DEFAULT,
   localparam int CW = (N_MAX > 1) ? $clog2(N_MAX) : 1,
   localparam int QW = CW + $bits(gfr_op_type),
   localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_empty,
   input  wire logic [QW-1:0]  q_data,
   output logic                q_pop,
   input  wire logic [OCW-1:0] out_count,
   output logic                out_push,
   output gfr_rsp_type         out_data
);

   localparam int UW = $clog2(OUT_DEPTH + PIPE_STAGES + 1);
   localparam int LS = PIPE_STAGES - 1;

   logic [CW-1:0] head_col;
   gfr_op_type    head_op;
   logic          hazard, dup, issue_load, issue_fma;
   logic [UW-1:0] used_slots;
   logic [31:0]   rd_data, res7_ff;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES-1:0] emit_ff, emit_in;
   logic [PIPE_STAGES-1:0] last_ff, last_in;
   logic [CW-1:0]          col_ff [PIPE_STAGES];
   logic [CW-1:0]          col_in [PIPE_STAGES];
   logic [CW+7:0]          col_wide;

   logic [31:0] a0_ff, b0_ff;
   logic        use_zero0_ff;

   logic [31:0] c1;
   logic        sa, sb, sc, ps, za, zb, zc;
   logic [7:0]  xa, xb, xc, ea_u, eb_u, ec_u;
   logic [22:0] fa, fb, fc;
   logic [23:0] ma, mb, mc;
   logic        nan_in, spec1;
   logic [31:0] spec_val1;
   logic [5:0]  tc, shc;
   logic [47:0] prod1_ff;
   logic [11:0] eab1_ff, ec1_ff;
   logic [63:0] rc1_ff;
   logic        ps1_ff, sc1_ff, zc1_ff, spec1_ff;
   logic [31:0] spec_val1_ff;

   logic [5:0]  tp, shp;
   logic [63:0] rp2_ff, rc2_ff;
   logic [11:0] ep2_ff, ec2_ff;
   logic        ps2_ff, sc2_ff, zc2_ff, spec2_ff;
   logic [31:0] spec_val2_ff;

   logic        p_big, sub3, sign3;
   logic [63:0] big3, sm3, al3;
   logic [11:0] d3, e3;
   logic [63:0] big3_ff, al3_ff;
   logic [11:0] e3_ff;
   logic        sub3_ff, sign3_ff, spec3_ff;
   logic [31:0] spec_val3_ff;

   logic [63:0] r4;
   logic [63:0] r4_ff;
   logic [11:0] e4_ff;
   logic        sign4_ff, spec4_ff;
   logic [31:0] spec_val4_ff;

   logic [5:0]  tr;
   logic [11:0] big_e, sh5, alt5;
   logic [63:0] r5_ff;
   logic [11:0] sh5_ff, e5_ff;
   logic        ovf5_ff, sign5_ff, spec5_ff;
   logic [31:0] spec_val5_ff;

   logic [11:0] nsh;
   logic [5:0]  shm1;
   logic [63:0] q6;
   logic        inc6;
   logic [24:0] q6_ff;
   logic [11:0] eq6_ff;
   logic        inc6_ff, ovf6_ff, sign6_ff, spec6_ff;
   logic [31:0] spec_val6_ff;

   logic [11:0] eqb;
   logic [35:0] sum7;
   logic [31:0] res7;

   assign head_col = q_data[QW-1 -: CW];
   assign head_op  = gfr_op_type'(q_data[$bits(gfr_op_type)-1:0]);

   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < PIPE_STAGES; i++) begin
         if (valid_ff[i] && (col_ff[i] == head_col)) begin
            hazard = 1'b1;
         end
      end
   end

   assign used_slots = UW'(out_count) + UW'($countones(valid_ff));
   assign issue_load = !q_empty && (head_op.kind == OP_LOAD) && (valid_ff == '0);
   assign issue_fma  = !q_empty && (head_op.kind == OP_FMA) && !hazard &&
                       (used_slots < UW'(OUT_DEPTH));
   assign q_pop      = issue_load || issue_fma;

   gfr_ram #(
      .WIDTH (32),
      .DEPTH (N_MAX)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (issue_load || valid_ff[LS]),
      .wr_addr (valid_ff[LS] ? col_ff[LS] : head_col),
      .wr_data (valid_ff[LS] ? res7_ff : head_op.b),
      .rd_addr (head_col),
      .rd_data (rd_data)
   );

   always_comb begin
      valid_in  = {valid_ff[PIPE_STAGES-2:0], issue_fma};
      emit_in   = {emit_ff[PIPE_STAGES-2:0], head_op.emit};
      last_in   = {last_ff[PIPE_STAGES-2:0], head_op.last};
      col_in[0] = head_col;
      for (int i = 1; i < PIPE_STAGES; i++) begin
         col_in[i] = col_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      emit_ff <= emit_in;
      last_ff <= last_in;
      for (int i = 0; i < PIPE_STAGES; i++) begin
         col_ff[i] <= col_in[i];
      end
      a0_ff        <= head_op.a;
      b0_ff        <= head_op.b;
      use_zero0_ff <= head_op.use_zero;
   end

   // Unpack, special operands, mantissa product and normalized addend.
   always_comb begin
      c1 = use_zero0_ff ? 32'd0 : rd_data;
      sa = a0_ff[31]; sb = b0_ff[31]; sc = c1[31];
      ps = sa ^ sb;
      xa = a0_ff[30:23]; xb = b0_ff[30:23]; xc = c1[30:23];
      fa = a0_ff[22:0];  fb = b0_ff[22:0];  fc = c1[22:0];
      za = (xa == 8'd0) && (fa == '0);
      zb = (xb == 8'd0) && (fb == '0);
      zc = (xc == 8'd0) && (fc == '0);
      nan_in = ((xa == 8'hFF) && (fa != '0)) || ((xb == 8'hFF) && (fb != '0)) ||
               ((xc == 8'hFF) && (fc != '0));
      spec1     = 1'b1;
      spec_val1 = c1;
      if (nan_in) begin
         spec_val1 = QNAN32;
      end else if ((xa == 8'hFF) || (xb == 8'hFF)) begin
         if (za || zb) begin
            spec_val1 = QNAN32;
         end else if ((xc == 8'hFF) && (sc != ps)) begin
            spec_val1 = QNAN32;
         end else begin
            spec_val1 = {ps, INF32[30:0]};
         end
      end else if (xc == 8'hFF) begin
         spec_val1 = c1;
      end else if (za || zb) begin
         if (zc) begin
            spec_val1 = (ps == sc) ? {ps, 31'd0} : 32'd0;
         end else begin
            spec_val1 = c1;
         end
      end else begin
         spec1 = 1'b0;
      end
      ma   = {(xa != 8'd0), fa};
      mb   = {(xb != 8'd0), fb};
      mc   = {(xc != 8'd0), fc};
      ea_u = (xa == 8'd0) ? 8'd1 : xa;
      eb_u = (xb == 8'd0) ? 8'd1 : xb;
      ec_u = (xc == 8'd0) ? 8'd1 : xc;
      tc   = top_bit64({40'd0, mc});
      shc  = 6'd61 - tc;
   end

   always_ff @(posedge clock) begin
      prod1_ff     <= {24'd0, ma} * {24'd0, mb};
      eab1_ff      <= {4'd0, ea_u} + {4'd0, eb_u} - 12'd300;
      rc1_ff       <= {40'd0, mc} << shc;
      ec1_ff       <= {4'd0, ec_u} - 12'd150 - {6'd0, shc};
      ps1_ff       <= ps;
      sc1_ff       <= sc;
      zc1_ff       <= zc;
      spec1_ff     <= spec1;
      spec_val1_ff <= spec_val1;
   end

   // Normalize the product.
   always_comb begin
      tp  = top_bit64({16'd0, prod1_ff});
      shp = 6'd61 - tp;
   end

   always_ff @(posedge clock) begin
      rp2_ff       <= {16'd0, prod1_ff} << shp;
      ep2_ff       <= eab1_ff - {6'd0, shp};
      rc2_ff       <= rc1_ff;
      ec2_ff       <= ec1_ff;
      ps2_ff       <= ps1_ff;
      sc2_ff       <= sc1_ff;
      zc2_ff       <= zc1_ff;
      spec2_ff     <= spec1_ff;
      spec_val2_ff <= spec_val1_ff;
   end

   // Order the operands by magnitude and align the smaller one with sticky.
   always_comb begin
      p_big = ($signed(ep2_ff) > $signed(ec2_ff)) ||
              ((ep2_ff == ec2_ff) && (rp2_ff >= rc2_ff));
      if (p_big) begin
         big3 = rp2_ff; sm3 = rc2_ff; d3 = ep2_ff - ec2_ff;
         sign3 = ps2_ff; e3 = ep2_ff;
      end else begin
         big3 = rc2_ff; sm3 = rp2_ff; d3 = ec2_ff - ep2_ff;
         sign3 = sc2_ff; e3 = ec2_ff;
      end
      sub3 = (ps2_ff != sc2_ff);
      if (d3 == 12'd0) begin
         al3 = sm3;
      end else if (d3 >= 12'd63) begin
         al3 = 64'd1;
      end else begin
         al3 = (sm3 >> d3[5:0]) | {63'd0, |(sm3 & ~({64{1'b1}} << d3[5:0]))};
      end
      if (zc2_ff) begin
         big3 = rp2_ff; al3 = 64'd0; sub3 = 1'b0; sign3 = ps2_ff; e3 = ep2_ff;
      end
   end

   always_ff @(posedge clock) begin
      big3_ff      <= big3;
      al3_ff       <= al3;
      e3_ff        <= e3;
      sub3_ff      <= sub3;
      sign3_ff     <= sign3;
      spec3_ff     <= spec2_ff;
      spec_val3_ff <= spec_val2_ff;
   end

   assign r4 = sub3_ff ? (big3_ff - al3_ff) : (big3_ff + al3_ff);

   always_ff @(posedge clock) begin
      r4_ff        <= r4;
      e4_ff        <= e3_ff;
      sign4_ff     <= sign3_ff;
      spec4_ff     <= spec3_ff || (sub3_ff && (r4 == 64'd0));
      spec_val4_ff <= spec3_ff ? spec_val3_ff : 32'd0;
   end

   // Leading one of the sum and the rounding position.
   always_comb begin
      tr    = top_bit64(r4_ff);
      big_e = {6'd0, tr} + e4_ff;
      sh5   = {6'd0, tr} - 12'd23;
      alt5  = 12'd0 - 12'd149 - e4_ff;
      if ($signed(alt5) > $signed(sh5)) begin
         sh5 = alt5;
      end
   end

   always_ff @(posedge clock) begin
      r5_ff        <= r4_ff;
      sh5_ff       <= sh5;
      e5_ff        <= e4_ff;
      ovf5_ff      <= $signed(big_e) > $signed(12'd127);
      sign5_ff     <= sign4_ff;
      spec5_ff     <= spec4_ff;
      spec_val5_ff <= spec_val4_ff;
   end

   // Shift to the result precision and decide the round-up.
   always_comb begin
      nsh  = 12'd0 - sh5_ff;
      shm1 = sh5_ff[5:0] - 6'd1;
      inc6 = 1'b0;
      if ($signed(sh5_ff) <= $signed(12'd0)) begin
         q6 = r5_ff << nsh[5:0];
      end else if ($signed(sh5_ff) >= $signed(12'd64)) begin
         q6 = 64'd0;
      end else begin
         q6   = r5_ff >> sh5_ff[5:0];
         inc6 = r5_ff[shm1] &&
                ((|(r5_ff & ~({64{1'b1}} << shm1))) || q6[0]);
      end
   end

   always_ff @(posedge clock) begin
      q6_ff        <= q6[24:0];
      eq6_ff       <= e5_ff + sh5_ff;
      inc6_ff      <= inc6;
      ovf6_ff      <= ovf5_ff;
      sign6_ff     <= sign5_ff;
      spec6_ff     <= spec5_ff;
      spec_val6_ff <= spec_val5_ff;
   end

   // Round, place the exponent and pack.
   always_comb begin
      eqb  = eq6_ff + 12'd149;
      sum7 = {11'd0, q6_ff} + {35'd0, inc6_ff} + ({24'd0, eqb} << 23);
      if (spec6_ff) begin
         res7 = spec_val6_ff;
      end else if (ovf6_ff || (sum7 >= {4'd0, INF32})) begin
         res7 = {sign6_ff, INF32[30:0]};
      end else begin
         res7 = {sign6_ff, sum7[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      res7_ff <= res7;
   end

   assign col_wide              = {8'd0, col_ff[LS]};
   assign out_push              = valid_ff[LS] && emit_ff[LS];
   assign out_data.column       = col_wide[7:0];
   assign out_data.result_value = res7_ff;
   assign out_data.last         = last_ff[LS];

   always_comb begin
      dup = 1'b0;
      for (int i = 0; i < PIPE_STAGES; i++) begin
         for (int j = i + 1; j < PIPE_STAGES; j++) begin
            if (valid_ff[i] && valid_ff[j] && (col_ff[i] == col_ff[j])) begin
               dup = 1'b1;
            end
         end
      end
   end

   a_ram_write_port: assert property (@(posedge clock) disable iff (reset)
      !(issue_load && valid_ff[LS]))
      else $error("Preload write collides with accumulator write-back.");

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> (out_count < OCW'(OUT_DEPTH)))
      else $error("Result pushed into a full output queue.");

   a_unique_columns: assert property (@(posedge clock) disable iff (reset)
      !dup)
      else $error("Two in-flight operations target the same column.");

endmodule
`default_nettype wire

// ----- hdl/gemv_fma_row_stream.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gemv_fma_row_stream
// Streaming binary32 matrix-vector product with fused multiply-add per step.
// ----------------------------------------------------------------------------
// A last-row B word passes the operation queue, the FMA pipeline and the
//   output queue before it shows on rsp.
// Throughput: one word per cycle while the output queue has room; a word
//   for a column still in the 8-stage FMA pipeline waits until its
//   write-back, and a C load waits for the pipeline to drain.
// Reset clears configuration (count_k 1, count_n 1, zero_mode 1), positions,
//   row multiplier and queues; the accumulator RAM holds garbage until loaded.
module gemv_fma_row_stream import gfr_pkg::*; #(
   parameter int N_MAX = N_MAX_DEFAULT,
   parameter int K_MAX = K_MAX_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COMMAND_W-1:0]   req_command,
   input  wire logic [VALUE_W-1:0]     req_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [COLUMN_W-1:0]    rsp_column,
   output logic      [VALUE_W-1:0]     rsp_result_value,
   output logic                        rsp_last,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CW  = (N_MAX > 1) ? $clog2(N_MAX) : 1;
   localparam int QW  = CW + $bits(gfr_op_type);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int OCW = $clog2(OUT_DEPTH + 1);
   localparam int RW  = $bits(gfr_rsp_type);

   logic           q_full, q_empty, q_push, q_pop;
   logic [QW-1:0]  q_push_data, q_data;
   logic [QCW-1:0] q_count;
   logic           out_push, out_empty, out_full;
   logic [OCW-1:0] out_count;
   gfr_rsp_type    out_data, rsp_word;
   logic [RW-1:0]  rsp_bits;

   gfr_front #(
      .N_MAX (N_MAX),
      .K_MAX (K_MAX)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   gfr_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full),
      .count     (q_count)
   );

   gfr_back #(
      .N_MAX (N_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_count (out_count),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   gfr_fifo #(
      .WIDTH (RW),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .pop       (rsp_valid && !rsp_stall),
      .pop_data  (rsp_bits),
      .empty     (out_empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_word         = gfr_rsp_type'(rsp_bits);
   assign rsp_valid        = !out_empty;
   assign rsp_column       = rsp_word.column;
   assign rsp_result_value = rsp_word.result_value;
   assign rsp_last         = rsp_word.last;

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      q_full |-> (q_count == QCW'(QUEUE_DEPTH)))
      else $error("Operation queue count disagrees with full flag.");

   a_rsp_not_full_push: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("Result word lost at a full output queue.");

   a_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result word present right after reset.");

endmodule
`default_nettype wire
